@@ hw/rtl/debounced_blink_rate_control_unit_macros.svh @@
// assertion helpers for the blink rate control checker
`ifndef DEBOUNCED_BLINK_RATE_CONTROL_UNIT_MACROS_SVH
`define DEBOUNCED_BLINK_RATE_CONTROL_UNIT_MACROS_SVH

// same-cycle implication, idle during reset
`define DBRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define DBRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/dbrc_pkg.sv @@
package dbrc_pkg;

  localparam int DebounceWidth = 10;
  localparam int PeriodWidth   = 12;
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 12;

  localparam logic [DebounceWidth-1:0] RunMax = '1;

  localparam logic [DebounceWidth-1:0] DebounceReset = 10'd50;
  localparam logic [PeriodWidth-1:0]   StepReset     = 12'd100;
  localparam logic [PeriodWidth-1:0]   MinReset      = 12'd50;
  localparam logic [PeriodWidth-1:0]   MaxReset      = 12'd2000;
  localparam logic [PeriodWidth-1:0]   InitialPeriod = 12'd500;

  localparam logic LevelLow  = 1'b0;
  localparam logic LevelHigh = 1'b1;

  localparam logic [CfgIndexWidth-1:0] RegDebounceTicks = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegPeriodStep    = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegMinPeriod     = 2'd2;
  localparam logic [CfgIndexWidth-1:0] RegMaxPeriod     = 2'd3;

  typedef struct packed {
    logic up;
    logic down;
  } press_t;

endpackage

@@ hw/rtl/dbrc_lane.sv @@
module dbrc_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 raw,
  input  logic [dbrc_pkg::DebounceWidth-1:0]   debounce_ticks,
  output logic                                 press
);

  logic                               prev_raw;
  logic                               acc_level;
  logic [dbrc_pkg::DebounceWidth-1:0] run;
  logic [dbrc_pkg::DebounceWidth-1:0] run_next;
  logic                               take;

  always_comb begin
    if (raw != prev_raw) begin
      run_next = '0;
    end else if (run == dbrc_pkg::RunMax) begin
      run_next = run;
    end else begin
      run_next = run + dbrc_pkg::DebounceWidth'(1);
    end
  end

  assign take  = (run_next >= debounce_ticks) && (acc_level != raw);
  assign press = take && (raw == dbrc_pkg::LevelLow);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw  <= dbrc_pkg::LevelHigh;
      acc_level <= dbrc_pkg::LevelHigh;
      run       <= '0;
    end else if (adv) begin
      prev_raw <= raw;
      run      <= run_next;
      if (take) begin
        acc_level <= raw;
      end
    end
  end

endmodule

@@ hw/rtl/dbrc_merge.sv @@
module dbrc_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  dbrc_pkg::press_t                    press,
  input  logic [dbrc_pkg::PeriodWidth-1:0]    period_step,
  input  logic [dbrc_pkg::PeriodWidth-1:0]    min_period,
  input  logic [dbrc_pkg::PeriodWidth-1:0]    max_period,
  output logic [dbrc_pkg::PeriodWidth-1:0]    half_period,
  output logic [dbrc_pkg::PeriodWidth-1:0]    half_period_next
);

  logic [dbrc_pkg::PeriodWidth:0]   lo_sum;
  logic [dbrc_pkg::PeriodWidth:0]   hi_sum;
  logic [dbrc_pkg::PeriodWidth-1:0] after_up;

  // up applies first, then down
  always_comb begin
    lo_sum = {1'b0, min_period} + {1'b0, period_step};
    if (!press.up) begin
      after_up = half_period;
    end else if ({1'b0, half_period} < lo_sum) begin
      after_up = min_period;
    end else begin
      after_up = half_period - period_step;
    end
    hi_sum = {1'b0, after_up} + {1'b0, period_step};
    if (!press.down) begin
      half_period_next = after_up;
    end else if (hi_sum > {1'b0, max_period}) begin
      half_period_next = max_period;
    end else begin
      half_period_next = hi_sum[dbrc_pkg::PeriodWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= dbrc_pkg::InitialPeriod;
    end else if (adv) begin
      half_period <= half_period_next;
    end
  end

endmodule

@@ hw/rtl/debounced_blink_rate_control_unit.sv @@
// channel | signals                      | moves
// in      | in_valid, in_ready           | one tick item: up_level, down_level
// out     | out_valid, out_ready         | led_level, period_now, up_press, down_press
// cfg     | cfg_we, cfg_index, cfg_data  | register write, no wait
// one item per cycle while the output is not stalled; result appears in the output register in the cycle after accept
// two debounce lanes and the period merge all finish within the accept cycle
// in_ready drops only while a result is held and out_ready is low
// rst is synchronous and clears all state and config registers to their defaults; output data registers are not reset
module debounced_blink_rate_control_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  up_level,
  input  logic                                  down_level,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  led_level,
  output logic [dbrc_pkg::PeriodWidth-1:0]      period_now,
  output logic                                  up_press,
  output logic                                  down_press,
  input  logic                                  cfg_we,
  input  logic [dbrc_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [dbrc_pkg::CfgDataWidth-1:0]     cfg_data
);

  logic [dbrc_pkg::DebounceWidth-1:0] debounce_ticks;
  logic [dbrc_pkg::PeriodWidth-1:0]   period_step;
  logic [dbrc_pkg::PeriodWidth-1:0]   min_period;
  logic [dbrc_pkg::PeriodWidth-1:0]   max_period;

  logic                               accept;
  dbrc_pkg::press_t                   press;
  logic [dbrc_pkg::PeriodWidth-1:0]   half_period;
  logic [dbrc_pkg::PeriodWidth-1:0]   half_period_next;

  logic [dbrc_pkg::PeriodWidth-1:0]   blink_count;
  logic [dbrc_pkg::PeriodWidth-1:0]   blink_count_next;
  logic [dbrc_pkg::PeriodWidth:0]     count_inc;
  logic                               wrap;
  logic                               led_on;
  logic                               led_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= dbrc_pkg::DebounceReset;
      period_step    <= dbrc_pkg::StepReset;
      min_period     <= dbrc_pkg::MinReset;
      max_period     <= dbrc_pkg::MaxReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dbrc_pkg::RegDebounceTicks: debounce_ticks <= cfg_data[dbrc_pkg::DebounceWidth-1:0];
        dbrc_pkg::RegPeriodStep:    period_step    <= cfg_data[dbrc_pkg::PeriodWidth-1:0];
        dbrc_pkg::RegMinPeriod:     min_period     <= cfg_data[dbrc_pkg::PeriodWidth-1:0];
        dbrc_pkg::RegMaxPeriod:     max_period     <= cfg_data[dbrc_pkg::PeriodWidth-1:0];
        default: ;
      endcase
    end
  end

  dbrc_lane u_up_lane (
    .clk            (clk),
    .rst            (rst),
    .adv            (accept),
    .raw            (up_level),
    .debounce_ticks (debounce_ticks),
    .press          (press.up)
  );

  dbrc_lane u_down_lane (
    .clk            (clk),
    .rst            (rst),
    .adv            (accept),
    .raw            (down_level),
    .debounce_ticks (debounce_ticks),
    .press          (press.down)
  );

  dbrc_merge u_merge (
    .clk              (clk),
    .rst              (rst),
    .adv              (accept),
    .press            (press),
    .period_step      (period_step),
    .min_period       (min_period),
    .max_period       (max_period),
    .half_period      (half_period),
    .half_period_next (half_period_next)
  );

  // blink uses the period in force before this tick's presses
  assign count_inc        = {1'b0, blink_count} + (dbrc_pkg::PeriodWidth+1)'(1);
  assign wrap             = count_inc >= {1'b0, half_period};
  assign blink_count_next = wrap ? '0 : count_inc[dbrc_pkg::PeriodWidth-1:0];
  assign led_next         = led_on ^ wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_count <= '0;
      led_on      <= 1'b0;
    end else if (accept) begin
      blink_count <= blink_count_next;
      led_on      <= led_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      led_level  <= led_next;
      period_now <= half_period_next;
      up_press   <= press.up;
      down_press <= press.down;
    end
  end

endmodule

@@ hw/rtl/dbrc_checker.sv @@
`include "debounced_blink_rate_control_unit_macros.svh"

module dbrc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               led_level,
  input logic [dbrc_pkg::PeriodWidth-1:0]   period_now,
  input logic                               up_press,
  input logic                               down_press
);

  `DBRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(led_level) && $stable(period_now) && $stable(up_press) && $stable(down_press), "held item changed while stalled")
  `DBRC_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "input not ready with empty output")
  `DBRC_ASSERT_NOW(a_full_stall, out_valid && !out_ready, !in_ready, "input taken while result stalled")
  `DBRC_ASSERT_NEXT(a_accept_out, in_valid && in_ready, out_valid, "accepted item produced no result")

endmodule

bind debounced_blink_rate_control_unit dbrc_checker u_dbrc_checker (.*);

@@ dv/debounced_blink_rate_control_unit_tb.sv @@
module debounced_blink_rate_control_unit_tb;

  localparam int WatchdogLimit = 5000;
  localparam int SqueezeCycles = 300;

  typedef struct packed {
    logic                             led;
    logic [dbrc_pkg::PeriodWidth-1:0] period;
    logic                             up_p;
    logic                             dn_p;
  } tick_result_t;

  typedef struct {
    bit                                 is_cfg;
    logic [dbrc_pkg::CfgIndexWidth-1:0] idx;
    logic [dbrc_pkg::CfgDataWidth-1:0]  data;
    logic                               up;
    logic                               dn;
    bit                                 typed;
    tick_result_t                       want;
  } dir_row_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               up_level = 1'b1;
  logic                               down_level = 1'b1;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic                               led_level;
  logic [dbrc_pkg::PeriodWidth-1:0]   period_now;
  logic                               up_press;
  logic                               down_press;
  logic                               cfg_we = 1'b0;
  logic [dbrc_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [dbrc_pkg::CfgDataWidth-1:0]  cfg_data = '0;

  debounced_blink_rate_control_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .up_level   (up_level),
    .down_level (down_level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .led_level  (led_level),
    .period_now (period_now),
    .up_press   (up_press),
    .down_press (down_press),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // predictor copy of the block
  logic [dbrc_pkg::DebounceWidth-1:0] db_ticks;
  logic [dbrc_pkg::PeriodWidth-1:0]   step_cfg;
  logic [dbrc_pkg::PeriodWidth-1:0]   min_cfg;
  logic [dbrc_pkg::PeriodWidth-1:0]   max_cfg;
  logic [dbrc_pkg::PeriodWidth-1:0]   blink_cnt;
  logic                               led_st;
  logic [dbrc_pkg::PeriodWidth-1:0]   half_per;
  logic                               prev_raw [2];
  logic [dbrc_pkg::DebounceWidth-1:0] run_len [2];
  logic                               acc_lvl [2];

  tick_result_t tick_results_q [$];
  dir_row_t     dir_rows [$];

  int  idle_mode = 1;
  bit  squeeze_req = 1'b0;
  bit  squeeze_done = 1'b0;
  bit  cfg_on = 1'b0;
  int  err_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  up_seen = 0;
  int  dn_seen = 0;
  int  settings_used = 0;
  int  stall_left = 0;
  int  idle_cyc = 0;
  logic btn_lvl [2];
  int  hold_left [2];

  function automatic void reset_blink_model();
    db_ticks  = dbrc_pkg::DebounceReset;
    step_cfg  = dbrc_pkg::StepReset;
    min_cfg   = dbrc_pkg::MinReset;
    max_cfg   = dbrc_pkg::MaxReset;
    blink_cnt = '0;
    led_st    = 1'b0;
    half_per  = dbrc_pkg::InitialPeriod;
    for (int i = 0; i < 2; i++) begin
      prev_raw[i] = dbrc_pkg::LevelHigh;
      run_len[i]  = '0;
      acc_lvl[i]  = dbrc_pkg::LevelHigh;
    end
  endfunction

  function automatic void config_blink_model(logic [dbrc_pkg::CfgIndexWidth-1:0] idx,
                                             logic [dbrc_pkg::CfgDataWidth-1:0] data);
    case (idx)
      dbrc_pkg::RegDebounceTicks: db_ticks = data[dbrc_pkg::DebounceWidth-1:0];
      dbrc_pkg::RegPeriodStep:    step_cfg = data[dbrc_pkg::PeriodWidth-1:0];
      dbrc_pkg::RegMinPeriod:     min_cfg  = data[dbrc_pkg::PeriodWidth-1:0];
      dbrc_pkg::RegMaxPeriod:     max_cfg  = data[dbrc_pkg::PeriodWidth-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic lane_press(int idx, logic raw);
    logic hit;
    hit = 1'b0;
    if (raw != prev_raw[idx]) begin
      run_len[idx] = '0;
    end else if (run_len[idx] < dbrc_pkg::RunMax) begin
      run_len[idx] = run_len[idx] + 1'b1;
    end
    prev_raw[idx] = raw;
    if (run_len[idx] >= db_ticks && acc_lvl[idx] != raw) begin
      acc_lvl[idx] = raw;
      hit = (raw == dbrc_pkg::LevelLow);
    end
    return hit;
  endfunction

  function automatic tick_result_t predict_tick(logic up, logic dn);
    int unsigned  nxt;
    int unsigned  h;
    int unsigned  st;
    int unsigned  mn;
    int unsigned  mx;
    logic         up_p;
    logic         dn_p;
    tick_result_t r;
    nxt = 32'(blink_cnt) + 32'd1;
    if (nxt >= 32'(half_per)) begin
      blink_cnt = '0;
      led_st = ~led_st;
    end else begin
      blink_cnt = dbrc_pkg::PeriodWidth'(nxt);
    end
    up_p = lane_press(0, up);
    dn_p = lane_press(1, dn);
    h  = 32'(half_per);
    st = 32'(step_cfg);
    mn = 32'(min_cfg);
    mx = 32'(max_cfg);
    if (up_p) h = (h < mn + st) ? mn : h - st;
    if (dn_p) h = (h + st > mx) ? mx : h + st;
    half_per = dbrc_pkg::PeriodWidth'(h);
    r.led    = led_st;
    r.period = half_per;
    r.up_p   = up_p;
    r.dn_p   = dn_p;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_mode == 0) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int next_hold(logic [dbrc_pkg::DebounceWidth-1:0] db);
    if (db >= 1000) return $urandom_range(1024, 1040);
    if ($urandom_range(0, 99) < 25) return $urandom_range(1, 3);
    return db + $urandom_range(1, 12);
  endfunction

  function automatic void add_cfg(logic [dbrc_pkg::CfgIndexWidth-1:0] idx,
                                  logic [dbrc_pkg::CfgDataWidth-1:0] data);
    dir_row_t row;
    row = '{is_cfg: 1'b1, idx: idx, data: data, up: 1'b1, dn: 1'b1, typed: 1'b0, want: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_tick(logic up, logic dn);
    dir_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, data: '0, up: up, dn: dn, typed: 1'b0, want: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_typed(logic up, logic dn, logic led, int period,
                                    logic up_p, logic dn_p);
    dir_row_t row;
    row = '{is_cfg: 1'b0, idx: '0, data: '0, up: up, dn: dn, typed: 1'b1,
            want: '{led, dbrc_pkg::PeriodWidth'(period), up_p, dn_p}};
    dir_rows.push_back(row);
  endfunction

  task automatic write_reg(logic [dbrc_pkg::CfgIndexWidth-1:0] idx,
                           logic [dbrc_pkg::CfgDataWidth-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    config_blink_model(idx, data);
    cfg_on = 1'b1;
  endtask

  task automatic close_cfg();
    if (cfg_on) begin
      cfg_we <= 1'b0;
      cfg_on = 1'b0;
      settings_used++;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic drive_tick(logic up, logic dn, bit typed, tick_result_t want);
    int           gap;
    tick_result_t pred;
    close_cfg();
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    up_level   <= up;
    down_level <= dn;
    do @(posedge clk); while (!in_ready);
    pred = predict_tick(up, dn);
    tick_results_q.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic set_all(logic [dbrc_pkg::CfgDataWidth-1:0] db,
                         logic [dbrc_pkg::CfgDataWidth-1:0] st,
                         logic [dbrc_pkg::CfgDataWidth-1:0] mn,
                         logic [dbrc_pkg::CfgDataWidth-1:0] mx);
    settle();
    write_reg(dbrc_pkg::RegDebounceTicks, db);
    write_reg(dbrc_pkg::RegPeriodStep, st);
    write_reg(dbrc_pkg::RegMinPeriod, mn);
    write_reg(dbrc_pkg::RegMaxPeriod, mx);
  endtask

  // mostly clean presses and releases with random hold times, some bounce and noise
  task automatic random_ticks(int n, int squeeze_at);
    logic u;
    logic d;
    for (int i = 0; i < n; i++) begin
      if (i == squeeze_at) squeeze_req = 1'b1;
      for (int b = 0; b < 2; b++) begin
        if (hold_left[b] == 0) begin
          btn_lvl[b] = ~btn_lvl[b];
          hold_left[b] = next_hold(db_ticks);
        end
        hold_left[b]--;
      end
      u = btn_lvl[0];
      d = btn_lvl[1];
      if ($urandom_range(0, 99) < 8) begin
        u = 1'($urandom_range(0, 1));
        d = 1'($urandom_range(0, 1));
      end
      drive_tick(u, d, 1'b0, '0);
    end
  endtask

  // receiver side: random stalls plus one long hold-off
  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{led_level, period_now, up_press, down_press};
      results_seen++;
      if (up_press) up_seen++;
      if (down_press) dn_seen++;
      if (tick_results_q.size() == 0) begin
        if (err_count < 10) $display("unexpected result led=%b period=%0d up=%b down=%b",
                                     got.led, got.period, got.up_p, got.dn_p);
        err_count++;
      end else begin
        want = tick_results_q.pop_front();
        if (got.led !== want.led || got.period !== want.period ||
            got.up_p !== want.up_p || got.dn_p !== want.dn_p) begin
          if (err_count < 10) begin
            $display("mismatch at result %0d: exp led=%b period=%0d up=%b down=%b",
                     results_seen, want.led, want.period, want.up_p, want.dn_p);
            $display("                      got led=%b period=%0d up=%b down=%b",
                     got.led, got.period, got.up_p, got.dn_p);
          end
          err_count++;
        end
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (squeeze_req && !squeeze_done) begin
      squeeze_done = 1'b1;
      stall_left = SqueezeCycles;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cyc = 0;
    end else begin
      idle_cyc++;
      if (idle_cyc >= WatchdogLimit) begin
        $display("timeout: no item moved for %0d cycles", WatchdogLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    reset_blink_model();

    add_typed(1'b1, 1'b1, 1'b0, 500, 1'b0, 1'b0);
    add_cfg(dbrc_pkg::RegDebounceTicks, 12'h400);
    add_typed(1'b0, 1'b1, 1'b0, 400, 1'b1, 1'b0);
    add_typed(1'b1, 1'b0, 1'b0, 500, 1'b0, 1'b1);
    add_typed(1'b1, 1'b1, 1'b0, 500, 1'b0, 1'b0);
    add_typed(1'b0, 1'b0, 1'b0, 500, 1'b1, 1'b1);
    add_cfg(dbrc_pkg::RegPeriodStep, 12'hFFF);
    add_cfg(dbrc_pkg::RegMinPeriod, 12'h000);
    add_tick(1'b1, 1'b1);
    add_tick(1'b0, 1'b1);
    add_tick(1'b1, 1'b1);
    add_tick(1'b1, 1'b1);
    add_tick(1'b1, 1'b1);
    add_cfg(dbrc_pkg::RegMaxPeriod, 12'hFFF);
    add_tick(1'b1, 1'b0);
    add_tick(1'b1, 1'b1);
    add_cfg(dbrc_pkg::RegMinPeriod, 12'd3000);
    add_cfg(dbrc_pkg::RegMaxPeriod, 12'd1000);
    add_cfg(dbrc_pkg::RegPeriodStep, 12'd1);
    add_tick(1'b1, 1'b1);
    add_tick(1'b1, 1'b0);
    add_tick(1'b0, 1'b1);
    add_tick(1'b1, 1'b1);
    add_tick(1'b0, 1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        if (!cfg_on) settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        drive_tick(dir_rows[i].up, dir_rows[i].dn, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    btn_lvl[0] = dbrc_pkg::LevelHigh;
    btn_lvl[1] = dbrc_pkg::LevelHigh;
    hold_left[0] = 0;
    hold_left[1] = 0;

    set_all(12'd3, 12'd7, 12'd1, 12'd40);
    random_ticks(40, 20);
    set_all(12'd0, 12'hFFF, 12'd0, 12'hFFF);
    random_ticks(40, -1);
    idle_mode = 0;
    set_all(12'd2, 12'd1, 12'hFFF, 12'd1);
    random_ticks(40, -1);
    idle_mode = 1;
    set_all({2'($urandom_range(0, 3)), 10'($urandom_range(0, 6))},
            12'($urandom), 12'($urandom), 12'($urandom));
    random_ticks(40, -1);
    set_all(12'd5, 12'd300, 12'd2, 12'd3000);
    random_ticks(40, -1);
    set_all({2'($urandom_range(0, 3)), 10'($urandom_range(0, 6))},
            12'($urandom), 12'($urandom), 12'($urandom));
    random_ticks(40, -1);

    // release both buttons, then one long press under the slowest debounce
    settle();
    write_reg(dbrc_pkg::RegDebounceTicks, 12'd0);
    drive_tick(dbrc_pkg::LevelHigh, dbrc_pkg::LevelHigh, 1'b0, '0);
    set_all(12'hFFF, dbrc_pkg::StepReset, dbrc_pkg::MinReset, dbrc_pkg::MaxReset);
    btn_lvl[0] = dbrc_pkg::LevelHigh;
    btn_lvl[1] = dbrc_pkg::LevelHigh;
    hold_left[0] = 0;
    hold_left[1] = 0;
    random_ticks(1045, -1);

    settle();
    repeat (4) @(posedge clk);
    $display("ran %0d ticks under %0d register settings, %0d results checked",
             items_sent, settings_used, results_seen);
    $display("saw %0d up presses and %0d down presses, %0d errors",
             up_seen, dn_seen, err_count);
    if (err_count == 0 && tick_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/dbrc_pkg.sv
hw/rtl/dbrc_lane.sv
hw/rtl/dbrc_merge.sv
hw/rtl/debounced_blink_rate_control_unit.sv
hw/rtl/dbrc_checker.sv
dv/debounced_blink_rate_control_unit_tb.sv
